### src/speck64_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// speck64_pkg
// Shared types and codes for the Speck 64-bit block cipher unit.
// ----------------------------------------------------------------------------
package speck64_pkg;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        CMD_EXPAND  = 2'd0,
        CMD_ENCRYPT = 2'd1,
        CMD_DECRYPT = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXPAND = 4'b0010,
        ST_ROUND  = 4'b0100,
        ST_FLUSH  = 4'b1000
    } state_t;

    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_COUNT = 3'd4;

    localparam logic [2:0] KEY_WORDS_THREE = 3'd3;
    localparam logic [2:0] KEY_WORDS_RESET = 3'd4;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t key;
        logic  decrypt;
    } round_in_t;

    typedef struct packed {
        word_t x;
        word_t y;
    } round_out_t;

endpackage : speck64_pkg
`default_nettype wire

### src/speck64_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// speck64_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module speck64_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 27
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : speck64_ram
`default_nettype wire

### src/speck64_round_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// speck64_round_unit
// One Speck round, forward or inverse. The forward round also serves as
// the key schedule step (x = schedule word, y = round key, key = index).
// ----------------------------------------------------------------------------
module speck64_round_unit
    import speck64_pkg::*;
#(
    parameter int ROT_ALPHA = 8,
    parameter int ROT_BETA  = 3
) (
    input  wire round_in_t  rnd_in,
    output round_out_t      rnd_out
);

    word_t enc_sum;
    word_t enc_x;
    word_t enc_y;
    word_t dec_mix;
    word_t dec_y;
    word_t dec_diff;
    word_t dec_x;

    assign enc_sum  = ((rnd_in.x >> ROT_ALPHA) | (rnd_in.x << (WORD_W - ROT_ALPHA)))
                    + rnd_in.y;
    assign enc_x    = enc_sum ^ rnd_in.key;
    assign enc_y    = ((rnd_in.y << ROT_BETA) | (rnd_in.y >> (WORD_W - ROT_BETA))) ^ enc_x;

    assign dec_mix  = rnd_in.x ^ rnd_in.y;
    assign dec_y    = (dec_mix >> ROT_BETA) | (dec_mix << (WORD_W - ROT_BETA));
    assign dec_diff = (rnd_in.x ^ rnd_in.key) - dec_y;
    assign dec_x    = (dec_diff << ROT_ALPHA) | (dec_diff >> (WORD_W - ROT_ALPHA));

    always_comb begin
        if (rnd_in.decrypt) begin
            rnd_out.x = dec_x;
            rnd_out.y = dec_y;
        end else begin
            rnd_out.x = enc_x;
            rnd_out.y = enc_y;
        end
    end

endmodule : speck64_round_unit
`default_nettype wire

### src/speck64_block_cipher_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// speck64_block_cipher_unit
// Speck 64/96 and 64/128 block cipher with a round-key memory.
//
// One item is in work at a time; s_ready is high while the unit is idle,
// also while a finished result still waits on the m_ channel. An expand
// item writes R round keys (R = 26 for three key words, 27 for any other
// key count, capped at MAX_ROUNDS) and gives no result. An encrypt or
// decrypt item runs R rounds of the single shared round unit, each fed by a
// round-key memory read issued in the cycle before it (the first one as the
// item is accepted), then loads the output register once the m_ channel is
// free. Before the first expansion an encrypt or decrypt item returns zero
// data with status 1. Key registers written after an expansion take effect
// only with the next expand item.
// ----------------------------------------------------------------------------
module speck64_block_cipher_unit
    import speck64_pkg::*;
#(
    parameter int MAX_ROUNDS = 27,
    parameter int ROT_ALPHA  = 8,
    parameter int ROT_BETA   = 3
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [31:0] s_block_x,
    input  wire logic [31:0] s_block_y,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_out_x,
    output logic [31:0]      m_out_y,
    output logic             m_status
);

    localparam int AW = $clog2(MAX_ROUNDS);
    localparam int CW = $clog2(MAX_ROUNDS + 1);
    localparam int R3 = (MAX_ROUNDS < 26) ? MAX_ROUNDS : 26;
    localparam int R4 = (MAX_ROUNDS < 27) ? MAX_ROUNDS : 27;

    // configuration
    word_t      key0_reg, key1_reg, key2_reg, key3_reg;
    logic [2:0] key_count_reg;
    logic       cfg_wr;

    // control
    state_t     state_reg, state_next;
    logic       keys_ready_reg, keys_ready_next;
    logic [CW-1:0] active_rounds_reg, active_rounds_next;
    logic [CW-1:0] rnd_cnt_reg, rnd_cnt_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic       dec_reg, dec_next;
    logic       words3_reg, words3_next;
    logic       m_valid_reg, m_valid_next;

    // datapath
    word_t      x_reg, x_next;
    word_t      y_reg, y_next;
    logic       status_reg, status_next;
    word_t      rk_cur_reg, rk_cur_next;
    word_t      sched0_reg, sched0_next;
    word_t      sched1_reg, sched1_next;
    word_t      sched2_reg, sched2_next;
    word_t      out_x_reg, out_x_next;
    word_t      out_y_reg, out_y_next;
    logic       out_status_reg, out_status_next;

    // memory and round unit
    logic          ram_wr_en;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    word_t         ram_rd_data;
    round_in_t     rnd_in;
    round_out_t    rnd_out;
    logic          last_round;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg      <= '0;
            key1_reg      <= '0;
            key2_reg      <= '0;
            key3_reg      <= '0;
            key_count_reg <= KEY_WORDS_RESET;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_KEY0:  key0_reg      <= pwdata;
                REG_KEY1:  key1_reg      <= pwdata;
                REG_KEY2:  key2_reg      <= pwdata;
                REG_KEY3:  key3_reg      <= pwdata;
                REG_COUNT: key_count_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_KEY0:  prdata = key0_reg;
            REG_KEY1:  prdata = key1_reg;
            REG_KEY2:  prdata = key2_reg;
            REG_KEY3:  prdata = key3_reg;
            REG_COUNT: prdata = {29'd0, key_count_reg};
            default:   prdata = '0;
        endcase
    end

    speck64_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ROUNDS)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (rnd_cnt_reg[AW-1:0]),
        .wr_data (rk_cur_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        if (state_reg == ST_EXPAND) begin
            rnd_in.x       = sched0_reg;
            rnd_in.y       = rk_cur_reg;
            rnd_in.key     = {{(WORD_W-CW){1'b0}}, rnd_cnt_reg};
            rnd_in.decrypt = 1'b0;
        end else begin
            rnd_in.x       = x_reg;
            rnd_in.y       = y_reg;
            rnd_in.key     = ram_rd_data;
            rnd_in.decrypt = dec_reg;
        end
    end

    speck64_round_unit #(
        .ROT_ALPHA (ROT_ALPHA),
        .ROT_BETA  (ROT_BETA)
    ) u_round (
        .rnd_in  (rnd_in),
        .rnd_out (rnd_out)
    );

    assign last_round = (rnd_cnt_reg == active_rounds_reg - CW'(1));
    assign s_ready    = (state_reg == ST_IDLE);

    always_comb begin
        state_next         = state_reg;
        keys_ready_next    = keys_ready_reg;
        active_rounds_next = active_rounds_reg;
        rnd_cnt_next       = rnd_cnt_reg;
        addr_next          = addr_reg;
        dec_next           = dec_reg;
        words3_next        = words3_reg;
        m_valid_next       = m_valid_reg;
        x_next             = x_reg;
        y_next             = y_reg;
        status_next        = status_reg;
        rk_cur_next        = rk_cur_reg;
        sched0_next        = sched0_reg;
        sched1_next        = sched1_reg;
        sched2_next        = sched2_reg;
        out_x_next         = out_x_reg;
        out_y_next         = out_y_reg;
        out_status_next    = out_status_reg;
        ram_wr_en          = 1'b0;
        ram_rd_en          = 1'b0;
        ram_rd_addr        = addr_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (cmd_t'(s_command))
                        CMD_EXPAND: begin
                            rk_cur_next        = key0_reg;
                            sched0_next        = key1_reg;
                            sched1_next        = key2_reg;
                            sched2_next        = key3_reg;
                            words3_next        = (key_count_reg == KEY_WORDS_THREE);
                            active_rounds_next = (key_count_reg == KEY_WORDS_THREE) ?
                                                 CW'(R3) : CW'(R4);
                            rnd_cnt_next       = '0;
                            state_next         = ST_EXPAND;
                        end
                        CMD_ENCRYPT, CMD_DECRYPT: begin
                            if (keys_ready_reg) begin
                                x_next       = s_block_x;
                                y_next       = s_block_y;
                                status_next  = 1'b0;
                                dec_next     = (cmd_t'(s_command) == CMD_DECRYPT);
                                rnd_cnt_next = '0;
                                ram_rd_en    = 1'b1;
                                ram_rd_addr  = (cmd_t'(s_command) == CMD_DECRYPT) ?
                                               AW'(active_rounds_reg - CW'(1)) : '0;
                                addr_next    = ram_rd_addr;
                                state_next   = ST_ROUND;
                            end else begin
                                x_next      = '0;
                                y_next      = '0;
                                status_next = 1'b1;
                                state_next  = ST_FLUSH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EXPAND: begin
                ram_wr_en = 1'b1;
                if (last_round) begin
                    keys_ready_next = 1'b1;
                    state_next      = ST_IDLE;
                end else begin
                    rk_cur_next  = rnd_out.y;
                    sched0_next  = sched1_reg;
                    if (words3_reg) begin
                        sched1_next = rnd_out.x;
                    end else begin
                        sched1_next = sched2_reg;
                        sched2_next = rnd_out.x;
                    end
                    rnd_cnt_next = rnd_cnt_reg + CW'(1);
                end
            end
            ST_ROUND: begin
                x_next = rnd_out.x;
                y_next = rnd_out.y;
                if (last_round) begin
                    state_next = ST_FLUSH;
                end else begin
                    rnd_cnt_next = rnd_cnt_reg + CW'(1);
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = dec_reg ? (addr_reg - AW'(1)) : (addr_reg + AW'(1));
                    addr_next    = ram_rd_addr;
                end
            end
            ST_FLUSH: begin
                if (!m_valid_reg || m_ready) begin
                    out_x_next      = x_reg;
                    out_y_next      = y_reg;
                    out_status_next = status_reg;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            keys_ready_reg    <= 1'b0;
            active_rounds_reg <= '0;
            rnd_cnt_reg       <= '0;
            addr_reg          <= '0;
            dec_reg           <= 1'b0;
            words3_reg        <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            keys_ready_reg    <= keys_ready_next;
            active_rounds_reg <= active_rounds_next;
            rnd_cnt_reg       <= rnd_cnt_next;
            addr_reg          <= addr_next;
            dec_reg           <= dec_next;
            words3_reg        <= words3_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        status_reg     <= status_next;
        rk_cur_reg     <= rk_cur_next;
        sched0_reg     <= sched0_next;
        sched1_reg     <= sched1_next;
        sched2_reg     <= sched2_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_status_reg <= out_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_out_x  = out_x_reg;
    assign m_out_y  = out_y_reg;
    assign m_status = out_status_reg;

    a_write_only_expand: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (state_reg == ST_EXPAND))
        else $error("key memory written outside expansion");

    a_expand_sets_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXPAND && last_round) |=> keys_ready_reg)
        else $error("expansion finished without keys ready");

    a_round_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> (keys_ready_reg && rnd_cnt_reg < active_rounds_reg))
        else $error("round count beyond active rounds");

    a_read_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_rd_en |-> (ram_rd_addr <= AW'(MAX_ROUNDS - 1)))
        else $error("key memory read address out of range");

    a_status_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_status_reg) |-> (out_x_reg == '0 && out_y_reg == '0))
        else $error("error status with nonzero data");

endmodule : speck64_block_cipher_unit
`default_nettype wire

### dv/speck64_result_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// speck64_result_checker
// Watches the register port and both item channels of the Speck 64-bit
// cipher unit. Keeps its own copy of the key registers and the round-key
// schedule, predicts each encrypt or decrypt result when its item is
// accepted, and compares the results in order as they leave the unit.
// ----------------------------------------------------------------------------
module speck64_result_checker
    import speck64_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,

    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [31:0] s_block_x,
    input  wire logic [31:0] s_block_y,

    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_out_x,
    input  wire logic [31:0] m_out_y,
    input  wire logic        m_status,

    output int               fail_count,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROUNDS = 27;
    localparam int ROT_ALPHA  = 8;
    localparam int ROT_BETA   = 3;

    typedef struct packed {
        word_t x;
        word_t y;
        logic  status;
    } block_result_t;

    word_t         key_words [4];
    logic [2:0]    key_count;
    word_t         round_keys [MAX_ROUNDS];
    int            active_rounds;
    logic          keys_ready;
    block_result_t expected_blocks [$];

    function automatic word_t rol(word_t v, int r);
        return (v << r) | (v >> (WORD_W - r));
    endfunction

    function automatic word_t ror(word_t v, int r);
        return (v >> r) | (v << (WORD_W - r));
    endfunction

    function automatic void expand_round_keys();
        word_t sched [3];
        word_t fresh;
        int    words;
        int    rounds;
        int    live_words;
        words = (key_count == KEY_WORDS_THREE) ? 3 : 4;
        rounds = (words == 3) ? 26 : 27;
        if (rounds > MAX_ROUNDS) begin
            rounds = MAX_ROUNDS;
        end
        live_words = words - 1;
        sched[0] = key_words[1];
        sched[1] = key_words[2];
        sched[2] = key_words[3];
        round_keys[0] = key_words[0];
        for (int i = 0; i + 1 < rounds; i++) begin
            fresh = (round_keys[i] + ror(sched[0], ROT_ALPHA)) ^ word_t'(i);
            for (int j = 0; j + 1 < live_words; j++) begin
                sched[j] = sched[j + 1];
            end
            sched[live_words - 1] = fresh;
            round_keys[i + 1] = rol(round_keys[i], ROT_BETA) ^ fresh;
        end
        active_rounds = rounds;
        keys_ready = 1'b1;
    endfunction

    function automatic block_result_t cipher_block(cmd_t cmd, word_t x, word_t y);
        block_result_t res;
        res = '0;
        if (!keys_ready) begin
            res.status = 1'b1;
            return res;
        end
        if (cmd == CMD_ENCRYPT) begin
            for (int i = 0; i < active_rounds; i++) begin
                x = (ror(x, ROT_ALPHA) + y) ^ round_keys[i];
                y = rol(y, ROT_BETA) ^ x;
            end
        end else begin
            for (int i = active_rounds - 1; i >= 0; i--) begin
                y = ror(x ^ y, ROT_BETA);
                x = rol((x ^ round_keys[i]) - y, ROT_ALPHA);
            end
        end
        res.x = x;
        res.y = y;
        return res;
    endfunction

    always @(posedge aclk) begin : monitor
        block_result_t want;
        if (!aresetn) begin
            foreach (key_words[i]) key_words[i] = '0;
            key_count = KEY_WORDS_RESET;
            keys_ready = 1'b0;
            active_rounds = 0;
            fail_count = 0;
            expected_blocks.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_KEY0:  key_words[0] = pwdata;
                    REG_KEY1:  key_words[1] = pwdata;
                    REG_KEY2:  key_words[2] = pwdata;
                    REG_KEY3:  key_words[3] = pwdata;
                    REG_COUNT: key_count = pwdata[2:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_blocks.size() == 0) begin
                    $error("unexpected result item: out_x %h out_y %h status %b",
                           m_out_x, m_out_y, m_status);
                    fail_count++;
                end else begin
                    want = expected_blocks.pop_front();
                    if (m_out_x !== want.x) begin
                        $error("out_x: expected %h, actual %h", want.x, m_out_x);
                        fail_count++;
                    end
                    if (m_out_y !== want.y) begin
                        $error("out_y: expected %h, actual %h", want.y, m_out_y);
                        fail_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %b, actual %b", want.status, m_status);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                case (s_command)
                    CMD_EXPAND: expand_round_keys();
                    CMD_ENCRYPT, CMD_DECRYPT:
                        expected_blocks.push_back(
                            cipher_block(cmd_t'(s_command), s_block_x, s_block_y));
                    default: ;
                endcase
            end
        end
        outstanding = expected_blocks.size();
    end

endmodule : speck64_result_checker
`default_nettype wire

### dv/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the Speck 64-bit cipher unit: known-answer and edge items,
// then random phases of key setup, expansion and encrypt/decrypt traffic
// with random gaps on both channels. Results are checked by the checker.
// ----------------------------------------------------------------------------
module testbench
    import speck64_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 32;
    localparam int         PHASES         = 8;
    localparam int         PHASE_ITEMS    = 50;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [31:0] s_block_x;
    logic [31:0] s_block_y;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_out_x;
    logic [31:0] m_out_y;
    logic        m_status;
    int          fail_count;
    int          outstanding;
    logic        steady;

    speck64_block_cipher_unit u_top (.*);

    speck64_result_checker u_check (.*);

    always #1 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic word_t pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom();
    endfunction

    function automatic logic [2:0] pick_count();
        int r;
        r = $urandom_range(0, 5);
        if (r < 2) return KEY_WORDS_THREE;
        if (r < 4) return KEY_WORDS_RESET;
        return 3'($urandom_range(0, 7));
    endfunction

    task automatic send_item(input logic [1:0] cmd, input word_t x, input word_t y);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_block_x <= x;
        s_block_y <= y;
        do @(posedge aclk); while (!s_ready);
    endtask

    // quiet the input side, collect every result, let a trailing expand finish
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input word_t data);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_keys(input word_t k0, input word_t k1, input word_t k2,
                              input word_t k3, input logic [2:0] count);
        word_t count_word;
        settle();
        count_word = $urandom();
        count_word[2:0] = count;
        apb_write(REG_KEY0, k0);
        apb_write(REG_KEY1, k1);
        apb_write(REG_KEY2, k2);
        apb_write(REG_KEY3, k3);
        apb_write(REG_COUNT, count_word);
    endtask

    initial begin : result_sink
        int stall;
        int run;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            stall = pick_gap();
            run = $urandom_range(1, 24);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat (run) @(negedge aclk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("testbench: errors");
        $finish;
    end

    initial begin : stimulus
        int         r;
        logic [1:0] cmd;
        aresetn   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_valid   = 1'b0;
        s_command = CMD_EXPAND;
        s_block_x = '0;
        s_block_y = '0;
        steady    = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // no schedule yet: status only
        send_item(CMD_ENCRYPT, '0, '0);
        send_item(CMD_DECRYPT, '1, '1);
        send_item(CMD_UNUSED, $urandom(), $urandom());
        send_item(CMD_ENCRYPT, $urandom(), $urandom());

        // 96-bit key, known answer
        write_keys(32'h03020100, 32'h0b0a0908, 32'h13121110, $urandom(), KEY_WORDS_THREE);
        send_item(CMD_EXPAND, '0, '0);
        send_item(CMD_ENCRYPT, 32'h74614620, 32'h736e6165);
        send_item(CMD_DECRYPT, 32'h9f7952ec, 32'h4175946c);
        send_item(CMD_ENCRYPT, '0, '0);
        send_item(CMD_ENCRYPT, '1, '1);
        send_item(CMD_DECRYPT, '0, '1);
        send_item(CMD_DECRYPT, '1, '0);
        send_item(CMD_UNUSED, '1, '1);

        // 128-bit key; old schedule holds until the next expand
        write_keys(32'h03020100, 32'h0b0a0908, 32'h13121110, 32'h1b1a1918,
                   KEY_WORDS_RESET);
        send_item(CMD_ENCRYPT, 32'h3b726574, 32'h7475432d);
        send_item(CMD_EXPAND, '0, '0);
        send_item(CMD_ENCRYPT, 32'h3b726574, 32'h7475432d);
        send_item(CMD_DECRYPT, 32'h8c6fa548, 32'h454e028b);

        write_keys('1, '1, '1, '1, 3'd7);
        send_item(CMD_EXPAND, '1, '1);
        send_item(CMD_ENCRYPT, '1, '0);
        send_item(CMD_DECRYPT, '0, '1);

        write_keys('0, '0, '0, '0, 3'd0);
        send_item(CMD_EXPAND, '0, '0);
        send_item(CMD_ENCRYPT, '1, '1);
        send_item(CMD_DECRYPT, '0, '0);

        for (int p = 0; p < PHASES; p++) begin
            write_keys(pick_word(), pick_word(), pick_word(), pick_word(), pick_count());
            steady = (p % 4 == 3);
            if ($urandom_range(0, 4) != 0) begin
                send_item(CMD_EXPAND, $urandom(), $urandom());
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 42) begin
                    cmd = CMD_ENCRYPT;
                end else if (r < 84) begin
                    cmd = CMD_DECRYPT;
                end else if (r < 94) begin
                    cmd = CMD_EXPAND;
                end else begin
                    cmd = CMD_UNUSED;
                end
                send_item(cmd, pick_word(), pick_word());
            end
        end

        settle();
        if (fail_count == 0 && outstanding == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule : testbench
`default_nettype wire
